// ===== rtl/core/bsrc_pkg.sv =====
// ----------------------------------------------------------------------------
// bsrc_pkg: shared types and constants of the banker's safety request check
// Sizes, command and status codes, beat field positions, and the structs
// that pass between the sequencer, the resource lanes and the merge stage.
// ----------------------------------------------------------------------------
package bsrc_pkg;

	localparam int PROCESSES   = 5;
	localparam int RESOURCES   = 3;
	localparam int AMOUNT_BITS = 8;
	localparam int WORK_W      = 13;

	localparam int PIDX_W = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
	localparam int CNT_W  = $clog2(PROCESSES + 1);

	// Field widths of the stream beats
	localparam int CMD_W     = 3;
	localparam int PROC_F_W  = 4;
	localparam int RES_F_W   = 2;
	localparam int VAL_F_W   = 8;
	localparam int AMT_F_W   = 8;
	localparam int STATUS_W  = 3;
	localparam int AMT_F_NUM = 3;

	// s_tdata: process, resource, value, amount_0, amount_1, amount_2
	localparam int F_PROC_LSB = 0;
	localparam int F_RES_LSB  = F_PROC_LSB + PROC_F_W;
	localparam int F_VAL_LSB  = F_RES_LSB + RES_F_W;
	localparam int F_AMT_LSB  = F_VAL_LSB + VAL_F_W;
	localparam int IN_BITS    = F_AMT_LSB + AMT_F_NUM * AMT_F_W;
	localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;

	// m_tdata: status, safe, seq_valid, seq_process
	localparam int OUT_BITS   = STATUS_W + 1 + 1 + PROC_F_W;
	localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;
	localparam int OUT_PAD_W  = OUT_DATA_W - OUT_BITS;

	// Signed compare width: covers the work vector, entries and request amounts
	localparam int CMP_BASE = (WORK_W > AMOUNT_BITS) ? WORK_W : AMOUNT_BITS;
	localparam int CMP_W    = ((CMP_BASE > AMT_F_W) ? CMP_BASE : AMT_F_W) + 2;

	localparam logic [PROC_F_W:0] PROC_LIMIT = (PROC_F_W + 1)'(PROCESSES);
	localparam logic [RES_F_W:0]  RES_LIMIT  = (RES_F_W + 1)'(RESOURCES);

	typedef enum logic [CMD_W-1:0] {
		CMD_LD_CLAIM = 3'd0,
		CMD_LD_HELD  = 3'd1,
		CMD_LD_FREE  = 3'd2,
		CMD_CHECK    = 3'd3,
		CMD_REQUEST  = 3'd4
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_OK        = 3'd0,
		STS_EXCEEDS   = 3'd1,
		STS_NOT_AVAIL = 3'd2,
		STS_UNSAFE    = 3'd3,
		STS_BAD_INDEX = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REQ_CHK,
		ST_INIT,
		ST_SCAN,
		ST_ROLLBACK,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic                   ld_claim;
		logic                   ld_held;
		logic                   ld_free;
		logic [PIDX_W-1:0]      ld_proc;
		logic [AMOUNT_BITS-1:0] ld_val;
		logic [PIDX_W-1:0]      sel_proc;
		logic                   grant;
		logic                   rollback;
		logic                   work_init;
		logic                   work_add;
	} lane_ctl_t;

	typedef struct packed {
		logic fits;
		logic over_need;
		logic lacks;
	} lane_stat_t;

	typedef struct packed {
		logic fits_all;
		logic any_over;
		logic any_lacks;
	} merge_t;

endpackage

// ===== rtl/core/bankers_safety_request_check.sv =====
// ----------------------------------------------------------------------------
// bankers_safety_request_check: deadlock-avoidance request checker
// Keeps claims, holdings and free units, answers load, safety check and
// request commands with a status beat or the safe order.
// ----------------------------------------------------------------------------
// Commands arrive one at a time on the s_ stream with the command code in
// s_tuser; a load returns one beat. A safety check first seeds the work
// vector in ST_INIT, then scans one process row per cycle, all resource
// types compared at once in their lanes, in repeated passes until every
// process has finished or a pass finishes none; a safe state then returns
// PROCESSES beats carrying the safe order, the last with tlast, an unsafe
// one a single status beat. A request first runs the need and availability
// test in ST_REQ_CHK before the scan, and after an unsafe scan a rollback
// in ST_ROLLBACK. The next command is taken once the output register is
// empty or its beat leaves in the same cycle; a stalled receiver holds the
// input off.
module bankers_safety_request_check (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// process[3:0], resource[5:4], value[13:6], amount_0[21:14],
	// amount_1[29:22], amount_2[37:30], zero fill
	input  logic [bsrc_pkg::IN_DATA_W-1:0]       s_tdata,
	// command[2:0]
	input  logic [bsrc_pkg::CMD_W-1:0]           s_tuser,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// status[2:0], safe[3], seq_valid[4], seq_process[8:5], zero fill
	output logic [bsrc_pkg::OUT_DATA_W-1:0]      m_tdata,
	output logic                                 m_tlast
);

	bsrc_pkg::lane_ctl_t           lane_ctl  [bsrc_pkg::RESOURCES];
	bsrc_pkg::lane_stat_t          lane_stat [bsrc_pkg::RESOURCES];
	logic [bsrc_pkg::AMT_F_W-1:0]  req       [bsrc_pkg::RESOURCES];
	bsrc_pkg::merge_t              merged;

	bsrc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.merged   (merged),
		.lane_ctl (lane_ctl),
		.req      (req)
	);

	for (genvar r = 0; r < bsrc_pkg::RESOURCES; r++) begin : g_lane
		bsrc_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (lane_ctl[r]),
			.req    (req[r]),
			.stat   (lane_stat[r])
		);
	end

	bsrc_merge u_merge (
		.stat   (lane_stat),
		.merged (merged)
	);

endmodule

// ===== rtl/core/bsrc_lane.sv =====
// ----------------------------------------------------------------------------
// bsrc_lane: one resource type column
// Holds claim and holding of every process for one resource type, its free
// units and its work entry; tests need against work and a request against
// need and free units for the selected process row.
// ----------------------------------------------------------------------------
module bsrc_lane (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  bsrc_pkg::lane_ctl_t                   ctl,
	input  logic [bsrc_pkg::AMT_F_W-1:0]          req,
	output bsrc_pkg::lane_stat_t                  stat
);

	logic [bsrc_pkg::AMOUNT_BITS-1:0] claim_q [bsrc_pkg::PROCESSES];
	logic [bsrc_pkg::AMOUNT_BITS-1:0] held_q  [bsrc_pkg::PROCESSES];
	logic [bsrc_pkg::AMOUNT_BITS-1:0] free_q;
	logic [bsrc_pkg::WORK_W-1:0]      work_q;

	logic [bsrc_pkg::AMOUNT_BITS-1:0] claim_sel;
	logic [bsrc_pkg::AMOUNT_BITS-1:0] held_sel;
	logic [bsrc_pkg::AMOUNT_BITS-1:0] req_amt;
	logic signed [bsrc_pkg::CMP_W-1:0] need;
	logic signed [bsrc_pkg::CMP_W-1:0] work_s;
	logic signed [bsrc_pkg::CMP_W-1:0] req_s;

	assign claim_sel = claim_q[ctl.sel_proc];
	assign held_sel  = held_q[ctl.sel_proc];
	assign req_amt   = bsrc_pkg::AMOUNT_BITS'(req);

	// Need may go negative when holding exceeds claim
	assign need   = $signed(bsrc_pkg::CMP_W'(claim_sel)) - $signed(bsrc_pkg::CMP_W'(held_sel));
	assign work_s = $signed(bsrc_pkg::CMP_W'(work_q));
	assign req_s  = $signed(bsrc_pkg::CMP_W'(req));

	assign stat.fits      = (need <= work_s);
	assign stat.over_need = (req_s > need);
	assign stat.lacks     = (bsrc_pkg::CMP_W'(req) > bsrc_pkg::CMP_W'(free_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < bsrc_pkg::PROCESSES; p++) begin
				claim_q[p] <= '0;
				held_q[p]  <= '0;
			end
			free_q <= '0;
			work_q <= '0;
		end else begin
			if (ctl.ld_claim) begin
				claim_q[ctl.ld_proc] <= ctl.ld_val;
			end
			if (ctl.ld_held) begin
				held_q[ctl.ld_proc] <= ctl.ld_val;
			end else if (ctl.grant) begin
				held_q[ctl.sel_proc] <= held_sel + req_amt;
			end else if (ctl.rollback) begin
				held_q[ctl.sel_proc] <= held_sel - req_amt;
			end
			if (ctl.ld_free) begin
				free_q <= ctl.ld_val;
			end else if (ctl.grant) begin
				free_q <= free_q - req_amt;
			end else if (ctl.rollback) begin
				free_q <= free_q + req_amt;
			end
			// Seed the work vector from the free units, or hand a finished process's holding back to it
			if (ctl.work_init) begin
				work_q <= bsrc_pkg::WORK_W'(free_q);
			end else if (ctl.work_add) begin
				work_q <= work_q + bsrc_pkg::WORK_W'(held_sel);
			end
		end
	end

endmodule

// ===== rtl/core/bsrc_merge.sv =====
// ----------------------------------------------------------------------------
// bsrc_merge: lane merge
// Combines the per-resource findings into one verdict for the selected row.
// ----------------------------------------------------------------------------
module bsrc_merge (
	input  bsrc_pkg::lane_stat_t stat [bsrc_pkg::RESOURCES],
	output bsrc_pkg::merge_t     merged
);

	always_comb begin
		merged.fits_all  = 1'b1;
		merged.any_over  = 1'b0;
		merged.any_lacks = 1'b0;
		for (int r = 0; r < bsrc_pkg::RESOURCES; r++) begin
			merged.fits_all  = merged.fits_all & stat[r].fits;
			merged.any_over  = merged.any_over | stat[r].over_need;
			merged.any_lacks = merged.any_lacks | stat[r].lacks;
		end
	end

endmodule

// ===== rtl/core/bsrc_ctrl.sv =====
// ----------------------------------------------------------------------------
// bsrc_ctrl: command sequencer
// Decodes commands, drives the lanes through request test, grant, safety
// scan and rollback, records the safe order and feeds the output register.
// ----------------------------------------------------------------------------
module bsrc_ctrl (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [bsrc_pkg::IN_DATA_W-1:0]       s_tdata,
	input  logic [bsrc_pkg::CMD_W-1:0]           s_tuser,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [bsrc_pkg::OUT_DATA_W-1:0]      m_tdata,
	output logic                                 m_tlast,
	input  bsrc_pkg::merge_t                     merged,
	output bsrc_pkg::lane_ctl_t                  lane_ctl [bsrc_pkg::RESOURCES],
	output logic [bsrc_pkg::AMT_F_W-1:0]         req [bsrc_pkg::RESOURCES]
);

	bsrc_pkg::state_t state_q, state_nx;

	logic                            m_valid_q;
	bsrc_pkg::status_t               status_q;
	logic                            safe_q;
	logic                            seqv_q;
	logic [bsrc_pkg::PROC_F_W-1:0]   seqp_q;
	logic                            last_q;

	logic [bsrc_pkg::PIDX_W-1:0]     proc_q;
	logic                            is_req_q;
	logic [bsrc_pkg::AMT_F_W-1:0]    req_q [bsrc_pkg::RESOURCES];
	logic [bsrc_pkg::PIDX_W-1:0]     scan_q;
	logic [bsrc_pkg::CNT_W-1:0]      done_q;
	logic                            progress_q;
	logic [bsrc_pkg::PROCESSES-1:0]  finished_q;
	logic [bsrc_pkg::PIDX_W-1:0]     order_q [bsrc_pkg::PROCESSES];
	logic [bsrc_pkg::PIDX_W-1:0]     emit_q;

	logic                            in_fire;
	logic                            out_free;
	bsrc_pkg::cmd_t                  cmd;
	logic [bsrc_pkg::PROC_F_W-1:0]   f_proc;
	logic [bsrc_pkg::RES_F_W-1:0]    f_res;
	logic                            proc_ok;
	logic                            res_ok;
	logic                            hit;
	logic                            scan_last;
	logic                            done_last;
	logic                            emit_last;

	bsrc_pkg::lane_ctl_t             ctl;
	logic                            out_load;
	bsrc_pkg::status_t               out_status;
	logic                            out_safe;
	logic                            out_seqv;
	logic [bsrc_pkg::PROC_F_W-1:0]   out_seqp;
	logic                            out_last;

	assign out_free  = !m_valid_q || m_tready;
	assign s_tready  = (state_q == bsrc_pkg::ST_IDLE) && out_free;
	assign in_fire   = s_tvalid && s_tready;

	assign cmd     = bsrc_pkg::cmd_t'(s_tuser);
	assign f_proc  = s_tdata[bsrc_pkg::F_PROC_LSB +: bsrc_pkg::PROC_F_W];
	assign f_res   = s_tdata[bsrc_pkg::F_RES_LSB +: bsrc_pkg::RES_F_W];
	assign proc_ok = {1'b0, f_proc} < bsrc_pkg::PROC_LIMIT;
	assign res_ok  = {1'b0, f_res} < bsrc_pkg::RES_LIMIT;

	assign scan_last = (scan_q == bsrc_pkg::PIDX_W'(bsrc_pkg::PROCESSES - 1));
	assign done_last = (done_q == bsrc_pkg::CNT_W'(bsrc_pkg::PROCESSES - 1));
	assign emit_last = (emit_q == bsrc_pkg::PIDX_W'(bsrc_pkg::PROCESSES - 1));
	assign hit       = (state_q == bsrc_pkg::ST_SCAN) && !finished_q[scan_q] && merged.fits_all;

	assign req      = req_q;
	assign m_tvalid = m_valid_q;
	assign m_tlast  = last_q;
	assign m_tdata  = {{bsrc_pkg::OUT_PAD_W{1'b0}}, seqp_q, seqv_q, safe_q, status_q};

	// Next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			bsrc_pkg::ST_IDLE: begin
				if (in_fire) begin
					if (cmd == bsrc_pkg::CMD_CHECK) begin
						state_nx = bsrc_pkg::ST_INIT;
					end else if (cmd == bsrc_pkg::CMD_REQUEST && proc_ok) begin
						state_nx = bsrc_pkg::ST_REQ_CHK;
					end
				end
			end
			bsrc_pkg::ST_REQ_CHK: begin
				if (merged.any_over || merged.any_lacks) begin
					state_nx = bsrc_pkg::ST_IDLE;
				end else begin
					state_nx = bsrc_pkg::ST_INIT;
				end
			end
			bsrc_pkg::ST_INIT: state_nx = bsrc_pkg::ST_SCAN;
			bsrc_pkg::ST_SCAN: begin
				if (hit && done_last) begin
					state_nx = bsrc_pkg::ST_EMIT;
				end else if (scan_last && !hit && !progress_q) begin
					state_nx = is_req_q ? bsrc_pkg::ST_ROLLBACK : bsrc_pkg::ST_IDLE;
				end
			end
			bsrc_pkg::ST_ROLLBACK: state_nx = bsrc_pkg::ST_IDLE;
			bsrc_pkg::ST_EMIT: begin
				if (out_free && emit_last) begin
					state_nx = bsrc_pkg::ST_IDLE;
				end
			end
			default: state_nx = bsrc_pkg::ST_IDLE;
		endcase
	end

	// Lane controls and output beat
	always_comb begin
		ctl          = '0;
		ctl.ld_proc  = f_proc[bsrc_pkg::PIDX_W-1:0];
		ctl.ld_val   = bsrc_pkg::AMOUNT_BITS'(s_tdata[bsrc_pkg::F_VAL_LSB +: bsrc_pkg::VAL_F_W]);
		ctl.sel_proc = proc_q;
		out_load     = 1'b0;
		out_status   = bsrc_pkg::STS_OK;
		out_safe     = 1'b0;
		out_seqv     = 1'b0;
		out_seqp     = '0;
		out_last     = 1'b1;
		unique case (state_q)
			bsrc_pkg::ST_IDLE: begin
				if (in_fire) begin
					unique case (cmd)
						bsrc_pkg::CMD_LD_CLAIM: begin
							out_load = 1'b1;
							if (proc_ok && res_ok) begin
								ctl.ld_claim = 1'b1;
							end else begin
								out_status = bsrc_pkg::STS_BAD_INDEX;
							end
						end
						bsrc_pkg::CMD_LD_HELD: begin
							out_load = 1'b1;
							if (proc_ok && res_ok) begin
								ctl.ld_held = 1'b1;
							end else begin
								out_status = bsrc_pkg::STS_BAD_INDEX;
							end
						end
						bsrc_pkg::CMD_LD_FREE: begin
							out_load = 1'b1;
							if (res_ok) begin
								ctl.ld_free = 1'b1;
							end else begin
								out_status = bsrc_pkg::STS_BAD_INDEX;
							end
						end
						bsrc_pkg::CMD_CHECK: ;
						bsrc_pkg::CMD_REQUEST: begin
							if (!proc_ok) begin
								out_load   = 1'b1;
								out_status = bsrc_pkg::STS_BAD_INDEX;
							end
						end
						default: ;
					endcase
				end
			end
			bsrc_pkg::ST_REQ_CHK: begin
				if (merged.any_over) begin
					out_load   = 1'b1;
					out_status = bsrc_pkg::STS_EXCEEDS;
				end else if (merged.any_lacks) begin
					out_load   = 1'b1;
					out_status = bsrc_pkg::STS_NOT_AVAIL;
				end else begin
					ctl.grant = 1'b1;
				end
			end
			bsrc_pkg::ST_INIT: ctl.work_init = 1'b1;
			bsrc_pkg::ST_SCAN: begin
				ctl.sel_proc = scan_q;
				ctl.work_add = hit;
				if (scan_last && !hit && !progress_q && !is_req_q) begin
					out_load   = 1'b1;
					out_status = bsrc_pkg::STS_UNSAFE;
				end
			end
			bsrc_pkg::ST_ROLLBACK: begin
				ctl.rollback = 1'b1;
				out_load     = 1'b1;
				out_status   = bsrc_pkg::STS_UNSAFE;
			end
			bsrc_pkg::ST_EMIT: begin
				if (out_free) begin
					out_load = 1'b1;
					out_safe = 1'b1;
					out_seqv = 1'b1;
					out_seqp = bsrc_pkg::PROC_F_W'(order_q[emit_q]);
					out_last = emit_last;
				end
			end
			default: ;
		endcase
		// Steer loads to the addressed resource lane only
		for (int r = 0; r < bsrc_pkg::RESOURCES; r++) begin
			lane_ctl[r]          = ctl;
			lane_ctl[r].ld_claim = ctl.ld_claim && (f_res == bsrc_pkg::RES_F_W'(r));
			lane_ctl[r].ld_held  = ctl.ld_held && (f_res == bsrc_pkg::RES_F_W'(r));
			lane_ctl[r].ld_free  = ctl.ld_free && (f_res == bsrc_pkg::RES_F_W'(r));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= bsrc_pkg::ST_IDLE;
			m_valid_q  <= 1'b0;
			is_req_q   <= 1'b0;
			scan_q     <= '0;
			done_q     <= '0;
			progress_q <= 1'b0;
			finished_q <= '0;
			emit_q     <= '0;
		end else begin
			state_q <= state_nx;
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			if (in_fire) begin
				is_req_q <= (cmd == bsrc_pkg::CMD_REQUEST);
			end
			if (state_q == bsrc_pkg::ST_INIT) begin
				scan_q     <= '0;
				done_q     <= '0;
				progress_q <= 1'b0;
				finished_q <= '0;
				emit_q     <= '0;
			end else if (state_q == bsrc_pkg::ST_SCAN) begin
				if (hit) begin
					finished_q[scan_q] <= 1'b1;
					done_q             <= done_q + 1'b1;
				end
				// Wrap to the next pass at the last row
				if (scan_last) begin
					scan_q     <= '0;
					progress_q <= 1'b0;
				end else begin
					scan_q     <= scan_q + 1'b1;
					progress_q <= progress_q | hit;
				end
			end else if (state_q == bsrc_pkg::ST_EMIT && out_free) begin
				emit_q <= emit_q + 1'b1;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (out_load) begin
			status_q <= out_status;
			safe_q   <= out_safe;
			seqv_q   <= out_seqv;
			seqp_q   <= out_seqp;
			last_q   <= out_last;
		end
		if (in_fire) begin
			proc_q <= f_proc[bsrc_pkg::PIDX_W-1:0];
			for (int r = 0; r < bsrc_pkg::RESOURCES; r++) begin
				req_q[r] <= s_tdata[bsrc_pkg::F_AMT_LSB + r * bsrc_pkg::AMT_F_W +: bsrc_pkg::AMT_F_W];
			end
		end
		if (hit) begin
			order_q[done_q[bsrc_pkg::PIDX_W-1:0]] <= scan_q;
		end
	end

endmodule

// ===== tb/tb_bankers_safety_request_check.sv =====
// ----------------------------------------------------------------------------
// tb_bankers_safety_request_check: self-checking bench of the request checker
// Drives load, safety check and request commands on the input stream, keeps
// its own copy of claims, holdings and free units to predict every status or
// safe-order beat, and compares the output stream beat by beat under random
// stalls on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_bankers_safety_request_check;
	import bsrc_pkg::*;

	localparam int LONG_HOLD    = 300;
	localparam int DRAIN_CYCLES = 120;
	localparam int RANDOM_ITEMS = 250;
	localparam int PAUSE_AT     = 120;
	localparam int QUIET_AT     = 200;
	localparam int HOLD_AT_BEAT = 60;

	typedef struct packed {
		status_t               status;
		logic                  safe;
		logic                  seq_valid;
		logic [PROC_F_W-1:0]   seq_process;
		logic                  last;
	} result_beat_t;

	class bankers_ledger;
		logic [AMOUNT_BITS-1:0] claim [PROCESSES][RESOURCES];
		logic [AMOUNT_BITS-1:0] held  [PROCESSES][RESOURCES];
		logic [AMOUNT_BITS-1:0] avail [RESOURCES];
		logic [PROC_F_W-1:0]    order [PROCESSES];
		result_beat_t           expected_beats [$];
		int                     errors;

		function new();
			for (int p = 0; p < PROCESSES; p++) begin
				order[p] = '0;
				for (int r = 0; r < RESOURCES; r++) begin
					claim[p][r] = '0;
					held[p][r]  = '0;
				end
			end
			for (int r = 0; r < RESOURCES; r++)
				avail[r] = '0;
			errors = 0;
		endfunction

		function int pending();
			return expected_beats.size();
		endfunction

		function int need_of(int p, int r);
			return int'(claim[p][r]) - int'(held[p][r]);
		endfunction

		// Repeated passes in process order; fills the safe order as it goes
		function bit state_is_safe();
			logic [WORK_W-1:0] work [RESOURCES];
			bit                done_flag [PROCESSES];
			int                count;
			bit                progress;
			bit                fits;
			for (int r = 0; r < RESOURCES; r++)
				work[r] = WORK_W'(avail[r]);
			for (int p = 0; p < PROCESSES; p++)
				done_flag[p] = 1'b0;
			count    = 0;
			progress = 1'b1;
			while (count < PROCESSES && progress) begin
				progress = 1'b0;
				for (int p = 0; p < PROCESSES; p++) begin
					if (!done_flag[p]) begin
						fits = 1'b1;
						for (int r = 0; r < RESOURCES; r++)
							if (need_of(p, r) > int'(work[r]))
								fits = 1'b0;
						if (fits) begin
							for (int r = 0; r < RESOURCES; r++)
								work[r] = work[r] + WORK_W'(held[p][r]);
							order[count] = PROC_F_W'(p);
							count++;
							done_flag[p] = 1'b1;
							progress     = 1'b1;
						end
					end
				end
			end
			return count == PROCESSES;
		endfunction

		function void push_status(status_t sts);
			result_beat_t b;
			b.status      = sts;
			b.safe        = 1'b0;
			b.seq_valid   = 1'b0;
			b.seq_process = '0;
			b.last        = 1'b1;
			expected_beats.push_back(b);
		endfunction

		function void push_order();
			result_beat_t b;
			for (int k = 0; k < PROCESSES; k++) begin
				b.status      = STS_OK;
				b.safe        = 1'b1;
				b.seq_valid   = 1'b1;
				b.seq_process = order[k];
				b.last        = (k == PROCESSES - 1);
				expected_beats.push_back(b);
			end
		endfunction

		function void note_command(logic [CMD_W-1:0] cmd, logic [PROC_F_W-1:0] proc,
				logic [RES_F_W-1:0] res, logic [VAL_F_W-1:0] val,
				logic [AMT_F_W-1:0] a0, logic [AMT_F_W-1:0] a1, logic [AMT_F_W-1:0] a2);
			logic [AMT_F_W-1:0] req [AMT_F_NUM];
			bit                 flag;
			int                 p;
			req[0] = a0;
			req[1] = a1;
			req[2] = a2;
			p      = int'(proc);
			case (cmd)
				CMD_LD_CLAIM, CMD_LD_HELD: begin
					if (p >= PROCESSES || int'(res) >= RESOURCES)
						push_status(STS_BAD_INDEX);
					else begin
						if (cmd == CMD_LD_CLAIM)
							claim[p][res] = AMOUNT_BITS'(val);
						else
							held[p][res] = AMOUNT_BITS'(val);
						push_status(STS_OK);
					end
				end
				CMD_LD_FREE: begin
					if (int'(res) >= RESOURCES)
						push_status(STS_BAD_INDEX);
					else begin
						avail[res] = AMOUNT_BITS'(val);
						push_status(STS_OK);
					end
				end
				CMD_CHECK: begin
					if (state_is_safe())
						push_order();
					else
						push_status(STS_UNSAFE);
				end
				CMD_REQUEST: begin
					if (p >= PROCESSES)
						push_status(STS_BAD_INDEX);
					else begin
						flag = 1'b0;
						for (int r = 0; r < RESOURCES; r++)
							if (int'(req[r]) > need_of(p, r))
								flag = 1'b1;
						if (flag)
							push_status(STS_EXCEEDS);
						else begin
							for (int r = 0; r < RESOURCES; r++)
								if (int'(req[r]) > int'(avail[r]))
									flag = 1'b1;
							if (flag)
								push_status(STS_NOT_AVAIL);
							else begin
								// grant tentatively, keep only if safe
								for (int r = 0; r < RESOURCES; r++) begin
									avail[r]   = avail[r] - AMOUNT_BITS'(req[r]);
									held[p][r] = held[p][r] + AMOUNT_BITS'(req[r]);
								end
								if (state_is_safe())
									push_order();
								else begin
									for (int r = 0; r < RESOURCES; r++) begin
										avail[r]   = avail[r] + AMOUNT_BITS'(req[r]);
										held[p][r] = held[p][r] - AMOUNT_BITS'(req[r]);
									end
									push_status(STS_UNSAFE);
								end
							end
						end
					end
				end
				default: begin
					// unused codes produce nothing
				end
			endcase
		endfunction

		function void check_beat(logic [OUT_DATA_W-1:0] data, logic tlast);
			result_beat_t got;
			result_beat_t want;
			got.status      = status_t'(data[STATUS_W-1:0]);
			got.safe        = data[STATUS_W];
			got.seq_valid   = data[STATUS_W+1];
			got.seq_process = data[STATUS_W+2 +: PROC_F_W];
			got.last        = tlast;
			if (expected_beats.size() == 0) begin
				$display("%0t: unexpected beat: expected none, actual %s%0d %s%0b %s%0b %s%0d %s%0b",
					$time, "status=", got.status, "safe=", got.safe,
					"seq_valid=", got.seq_valid, "seq=", got.seq_process,
					"last=", got.last);
				errors++;
				return;
			end
			want = expected_beats.pop_front();
			if (got.status !== want.status || got.safe !== want.safe ||
					got.seq_valid !== want.seq_valid ||
					got.seq_process !== want.seq_process || got.last !== want.last) begin
				$display("%0t: beat mismatch: expected %s%0d %s%0b %s%0b %s%0d %s%0b",
					$time, "status=", want.status, "safe=", want.safe,
					"seq_valid=", want.seq_valid, "seq=", want.seq_process,
					"last=", want.last);
				$display("%0t: beat mismatch: actual   %s%0d %s%0b %s%0b %s%0d %s%0b",
					$time, "status=", got.status, "safe=", got.safe,
					"seq_valid=", got.seq_valid, "seq=", got.seq_process,
					"last=", got.last);
				errors++;
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic [CMD_W-1:0]      s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tlast;
	bit                    quiet;

	bankers_ledger ledger = new();

	bankers_safety_request_check u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	task automatic idle_gap(input int cycles);
		@(negedge clk);
		s_tvalid <= 1'b0;
		repeat (cycles - 1) @(negedge clk);
	endtask

	task automatic issue_command(input logic [CMD_W-1:0] cmd, input logic [PROC_F_W-1:0] proc,
			input logic [RES_F_W-1:0] res, input logic [VAL_F_W-1:0] val,
			input logic [AMT_F_W-1:0] a0, input logic [AMT_F_W-1:0] a1,
			input logic [AMT_F_W-1:0] a2);
		logic [IN_DATA_W-1:0] beat;
		if (!quiet && $urandom_range(0, 3) == 0)
			idle_gap($urandom_range(1, 10));
		beat = '0;
		beat[F_PROC_LSB +: PROC_F_W]          = proc;
		beat[F_RES_LSB +: RES_F_W]            = res;
		beat[F_VAL_LSB +: VAL_F_W]            = val;
		beat[F_AMT_LSB +: AMT_F_W]            = a0;
		beat[F_AMT_LSB + AMT_F_W +: AMT_F_W]  = a1;
		beat[F_AMT_LSB + 2*AMT_F_W +: AMT_F_W] = a2;
		@(negedge clk);
		s_tdata  <= beat;
		s_tuser  <= cmd;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		ledger.note_command(cmd, proc, res, val, a0, a1, a2);
	endtask

	task automatic load_entry(input cmd_t cmd, input int proc, input int res, input int val);
		issue_command(cmd, PROC_F_W'(proc), RES_F_W'(res), VAL_F_W'(val), '0, '0, '0);
	endtask

	task automatic request_units(input int proc, input int a0, input int a1, input int a2);
		issue_command(CMD_REQUEST, PROC_F_W'(proc), '0, '0,
			AMT_F_W'(a0), AMT_F_W'(a1), AMT_F_W'(a2));
	endtask

	task automatic run_check();
		issue_command(CMD_CHECK, '0, '0, '0, '0, '0, '0);
	endtask

	// Hold off the sender until every predicted beat has come back
	task automatic drain_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (ledger.pending() != 0) @(posedge clk);
	endtask

	task automatic random_command();
		logic [CMD_W-1:0]    cmd;
		logic [PROC_F_W-1:0] proc;
		logic [RES_F_W-1:0]  res;
		logic [VAL_F_W-1:0]  val;
		logic [AMT_F_W-1:0]  amt [AMT_F_NUM];
		int                  pick;
		bit                  wide;
		pick = $urandom_range(0, 99);
		wide = ($urandom_range(0, 15) == 0);
		if ($urandom_range(0, 15) == 0)
			proc = PROC_F_W'($urandom_range(PROCESSES, (1 << PROC_F_W) - 1));
		else
			proc = PROC_F_W'($urandom_range(0, PROCESSES - 1));
		if ($urandom_range(0, 15) == 0)
			res = RES_F_W'($urandom_range(RESOURCES, (1 << RES_F_W) - 1));
		else
			res = RES_F_W'($urandom_range(0, RESOURCES - 1));
		for (int r = 0; r < AMT_F_NUM; r++)
			amt[r] = wide ? AMT_F_W'($urandom) : AMT_F_W'($urandom_range(0, 3));
		if (pick < 28) begin
			cmd = CMD_LD_CLAIM;
			val = wide ? VAL_F_W'($urandom) : VAL_F_W'($urandom_range(0, 10));
		end else if (pick < 50) begin
			cmd = CMD_LD_HELD;
			val = wide ? VAL_F_W'($urandom) : VAL_F_W'($urandom_range(0, 6));
		end else if (pick < 60) begin
			cmd = CMD_LD_FREE;
			val = wide ? VAL_F_W'($urandom) : VAL_F_W'($urandom_range(0, 8));
		end else begin
			val = VAL_F_W'($urandom);
			if (pick < 72)
				cmd = CMD_CHECK;
			else if (pick < 96)
				cmd = CMD_REQUEST;
			else
				cmd = CMD_W'($urandom_range(CMD_REQUEST + 1, (1 << CMD_W) - 1));
		end
		issue_command(cmd, proc, res, val, amt[0], amt[1], amt[2]);
	endtask

	// Output side: random stalls plus one long hold once traffic is flowing
	initial begin
		int stall_left;
		int beats;
		bit held_off;
		stall_left = 0;
		beats      = 0;
		held_off   = 1'b0;
		m_tready   = 1'b0;
		forever begin
			@(negedge clk);
			if (!held_off && beats >= HOLD_AT_BEAT) begin
				held_off   = 1'b1;
				stall_left = LONG_HOLD;
			end else if (stall_left == 0 && !quiet && $urandom_range(0, 5) == 0)
				stall_left = $urandom_range(1, 10);
			if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else
				m_tready <= 1'b1;
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				ledger.check_beat(m_tdata, m_tlast);
				beats++;
			end
		end
	end

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = '0;
		quiet    = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// all zero state is trivially safe
		run_check();
		load_entry(CMD_LD_CLAIM, 15, 0, 5);
		load_entry(CMD_LD_HELD, 0, 3, 5);
		load_entry(CMD_LD_FREE, 0, 3, 5);
		// free-units load ignores the process field
		load_entry(CMD_LD_FREE, 15, 0, 2);
		load_entry(CMD_LD_FREE, 0, 1, 2);
		load_entry(CMD_LD_FREE, 0, 2, 2);
		load_entry(CMD_LD_CLAIM, 0, 0, 4);
		load_entry(CMD_LD_HELD, 0, 0, 1);
		load_entry(CMD_LD_CLAIM, 1, 0, 3);
		load_entry(CMD_LD_HELD, 1, 0, 2);
		run_check();
		request_units(0, 4, 0, 0);
		request_units(0, 3, 0, 0);
		request_units(0, 2, 0, 0);
		request_units(0, 1, 0, 0);
		// holding above claim: negative need
		load_entry(CMD_LD_HELD, 2, 1, 9);
		request_units(2, 0, 0, 0);
		run_check();
		request_units(7, 0, 0, 0);
		request_units(15, 1, 1, 1);
		for (int c = CMD_REQUEST + 1; c < (1 << CMD_W); c++)
			issue_command(CMD_W'(c), '1, '1, '1, '1, '1, '1);
		load_entry(CMD_LD_CLAIM, 4, 2, 255);
		run_check();
		load_entry(CMD_LD_CLAIM, 4, 2, 0);
		request_units(3, 255, 255, 255);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == PAUSE_AT)
				drain_results();
			if (i == QUIET_AT)
				quiet = 1'b1;
			random_command();
		end

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (ledger.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (ledger.errors == 0)
			$display("[bankers_safety_request_check] OK");
		else
			$display("[bankers_safety_request_check] ERROR");
		$finish;
	end

	initial begin
		#3_000_000;
		$display("[bankers_safety_request_check] ERROR");
		$finish;
	end

endmodule
